/* src/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the primitive plane splitter
// Fixed-point formats, payload structs, codes and the crossing-unit port.
// ----------------------------------------------------------------------------
package pps_pkg;
	localparam int COORD_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int NORM_BITS    = 18;
	localparam int BAND_BITS    = 16;
	localparam int TAG_BITS     = 16;
	localparam int T_BITS       = 30;
	localparam int T_LO_BITS    = T_BITS / 2;
	localparam int T_HI_BITS    = T_BITS - T_LO_BITS;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = NORM_BITS + DIFF_BITS;
	localparam int DIST_BITS    = PROD_BITS + 2;
	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 3;

	localparam logic signed [NORM_BITS-1:0] NORM_Z_RESET = NORM_BITS'(1 << FRAC_BITS);
	localparam logic [BAND_BITS-1:0]        BAND_RESET   = BAND_BITS'(1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [2:0]                 vec3_t;
	typedef vec3_t [2:0]                  vtx3_t;
	typedef logic signed [DIST_BITS-1:0]  dist_t;

	typedef enum logic [1:0] {
		KIND_TRI   = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_POINT = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SIDE_ON    = 2'd0,
		SIDE_FRONT = 2'd1,
		SIDE_BACK  = 2'd2
	} side_t;

	typedef enum logic [1:0] {
		SEL_ORIG = 2'd0,
		SEL_X1   = 2'd1,
		SEL_X2   = 2'd2,
		SEL_ZERO = 2'd3
	} vsel_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NORMAL_X  = 3'd0,
		REG_NORMAL_Y  = 3'd1,
		REG_NORMAL_Z  = 3'd2,
		REG_ANCHOR_X  = 3'd3,
		REG_ANCHOR_Y  = 3'd4,
		REG_ANCHOR_Z  = 3'd5,
		REG_DEAD_BAND = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_BITS-1:0] tag;
		coord_t              v0_x;
		coord_t              v0_y;
		coord_t              v0_z;
		coord_t              v1_x;
		coord_t              v1_y;
		coord_t              v1_z;
		coord_t              v2_x;
		coord_t              v2_y;
		coord_t              v2_z;
	} in_item_t;

	typedef struct packed {
		side_t               side;
		logic [TAG_BITS-1:0] src_tag;
		coord_t              p0_x;
		coord_t              p0_y;
		coord_t              p0_z;
		coord_t              p1_x;
		coord_t              p1_y;
		coord_t              p1_z;
		coord_t              p2_x;
		coord_t              p2_y;
		coord_t              p2_z;
		logic                last_piece;
	} out_item_t;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_BITS-1:0] tag;
		vtx3_t               vtx;
		dist_t [2:0]         vdist;
		side_t [2:0]         side;
	} q_entry_t;

	typedef struct packed {
		logic  start;
		vec3_t pa;
		vec3_t pb;
		dist_t da;
		dist_t db;
	} xreq_t;

	typedef struct packed {
		logic  done;
		vec3_t res;
	} xrsp_t;
endpackage

/* src/pps_front.sv */
// ----------------------------------------------------------------------------
// pps_front: plane registers and vertex classification pipeline
// Four stages: capture, vertex minus anchor, normal product, distance sum.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_item,
	output logic                    push,
	output q_entry_t                push_entry,
	input  logic                    q_full
);
	logic signed [NORM_BITS-1:0] normal_q [3];
	coord_t                      anchor_q [3];
	logic [BAND_BITS-1:0]        dead_band_q;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	in_item_t            item_s1;
	vtx3_t               vtx_s1;
	kind_t               kind_s2, kind_s3, kind_s4;
	logic [TAG_BITS-1:0] tag_s2, tag_s3, tag_s4;
	vtx3_t               vtx_s2, vtx_s3, vtx_s4;

	logic signed [DIFF_BITS-1:0] diff_s2 [3][3];
	logic signed [PROD_BITS-1:0] prod_s3 [3][3];
	dist_t                       dist_s4 [3];

	logic signed [PROD_BITS-1:0] nrm_ext [3];
	logic signed [PROD_BITS-1:0] diff_ext [3][3];
	dist_t                       thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= NORM_Z_RESET;
			anchor_q[0] <= '0;
			anchor_q[1] <= '0;
			anchor_q[2] <= '0;
			dead_band_q <= BAND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL_X:  normal_q[0] <= cfg_data[NORM_BITS-1:0];
				REG_NORMAL_Y:  normal_q[1] <= cfg_data[NORM_BITS-1:0];
				REG_NORMAL_Z:  normal_q[2] <= cfg_data[NORM_BITS-1:0];
				REG_ANCHOR_X:  anchor_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_ANCHOR_Y:  anchor_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_ANCHOR_Z:  anchor_q[2] <= cfg_data[COORD_BITS-1:0];
				REG_DEAD_BAND: dead_band_q <= cfg_data[BAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !(valid_s4 && (kind_s4 != KIND_EMPTY) && q_full);
	assign in_stall = !adv;
	assign push     = valid_s4 && (kind_s4 != KIND_EMPTY) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		vtx_s1[0][0] = item_s1.v0_x;
		vtx_s1[0][1] = item_s1.v0_y;
		vtx_s1[0][2] = item_s1.v0_z;
		vtx_s1[1][0] = item_s1.v1_x;
		vtx_s1[1][1] = item_s1.v1_y;
		vtx_s1[1][2] = item_s1.v1_z;
		vtx_s1[2][0] = item_s1.v2_x;
		vtx_s1[2][1] = item_s1.v2_y;
		vtx_s1[2][2] = item_s1.v2_z;
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nrm_ext[j] = PROD_BITS'(normal_q[j]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				diff_ext[i][j] = PROD_BITS'(diff_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			kind_s2 <= item_s1.kind;
			tag_s2  <= item_s1.tag;
			vtx_s2  <= vtx_s1;
			kind_s3 <= kind_s2;
			tag_s3  <= tag_s2;
			vtx_s3  <= vtx_s2;
			kind_s4 <= kind_s3;
			tag_s4  <= tag_s3;
			vtx_s4  <= vtx_s3;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					diff_s2[i][j] <= DIFF_BITS'($signed(vtx_s1[i][j]))
						- DIFF_BITS'(anchor_q[j]);
					prod_s3[i][j] <= nrm_ext[j] * diff_ext[i][j];
				end
				dist_s4[i] <= DIST_BITS'(prod_s3[i][0]) + DIST_BITS'(prod_s3[i][1])
					+ DIST_BITS'(prod_s3[i][2]);
			end
		end
	end

	assign thr = dist_t'({dead_band_q, {FRAC_BITS{1'b0}}});

	always_comb begin
		push_entry.kind = kind_s4;
		push_entry.tag  = tag_s4;
		push_entry.vtx  = vtx_s4;
		for (int i = 0; i < 3; i++) begin
			push_entry.vdist[i] = dist_s4[i];
			if (dist_s4[i] > thr) begin
				push_entry.side[i] = SIDE_FRONT;
			end else if (dist_s4[i] < -thr) begin
				push_entry.side[i] = SIDE_BACK;
			end else begin
				push_entry.side[i] = SIDE_ON;
			end
		end
	end
endmodule

/* src/pps_queue.sv */
// ----------------------------------------------------------------------------
// pps_queue: short queue of classified primitives
// Decouples the classification pipeline from the splitting back end.
// ----------------------------------------------------------------------------
module pps_queue import pps_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	q_entry_t              mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_q, rd_q;
	logic [CNT_BITS-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_BITS'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end
endmodule

/* src/pps_cross.sv */
// ----------------------------------------------------------------------------
// pps_cross: edge/plane crossing point unit
// Restoring division for t, split multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module pps_cross import pps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  xreq_t xreq,
	output xrsp_t xrsp
);
	localparam int MAG_BITS  = DIST_BITS;
	localparam int REM_BITS  = MAG_BITS + 2;
	localparam int CNT_BITS  = $clog2(T_BITS);
	localparam int PART_BITS = COORD_BITS + T_HI_BITS;
	localparam int ACC_BITS  = COORD_BITS + T_BITS + 1;
	localparam int STEP_BITS = COORD_BITS + 2;
	localparam logic [ACC_BITS-1:0] ROUND = ACC_BITS'(1) << (T_BITS - 1);

	typedef enum logic [2:0] {C_IDLE, C_PREP, C_DIV, C_MUL, C_SUM, C_ADD} state_t;

	state_t                state_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;

	logic [MAG_BITS-1:0]   ma_q, mb_q;
	logic [MAG_BITS:0]     den_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [T_BITS-1:0]     quo_q;
	vec3_t                 pa_q;
	vec3_t                 res_q;
	logic signed [DIFF_BITS-1:0] delta_q [3];
	logic [COORD_BITS-1:0] mag_q [3];
	logic                  neg_q [3];
	logic [PART_BITS-1:0]  ph_q [3], pl_q [3];
	logic [COORD_BITS-1:0] step_q [3];

	logic [REM_BITS-1:0]   rem_sh;
	logic                  ge;
	logic [ACC_BITS-1:0]   acc [3];
	logic signed [STEP_BITS-1:0] sum_v [3];

	assign rem_sh = {rem_q[REM_BITS-2:0], 1'b0};
	assign ge     = (rem_sh >= REM_BITS'(den_q));

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = (ACC_BITS'(ph_q[j]) << T_LO_BITS) + ACC_BITS'(pl_q[j]) + ROUND;
			if (neg_q[j]) begin
				sum_v[j] = STEP_BITS'($signed(pa_q[j])) - $signed({2'b00, step_q[j]});
			end else begin
				sum_v[j] = STEP_BITS'($signed(pa_q[j])) + $signed({2'b00, step_q[j]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_ADD);
			unique case (state_q)
				C_IDLE: if (xreq.start) state_q <= C_PREP;
				C_PREP: begin
					cnt_q   <= CNT_BITS'(T_BITS - 1);
					state_q <= C_DIV;
				end
				C_DIV: begin
					if (cnt_q == '0) begin
						state_q <= C_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				C_MUL: state_q <= C_SUM;
				C_SUM: state_q <= C_ADD;
				C_ADD: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				ma_q <= xreq.da[DIST_BITS-1] ? MAG_BITS'(-xreq.da) : MAG_BITS'(xreq.da);
				mb_q <= xreq.db[DIST_BITS-1] ? MAG_BITS'(-xreq.db) : MAG_BITS'(xreq.db);
				pa_q <= xreq.pa;
				for (int j = 0; j < 3; j++) begin
					delta_q[j] <= DIFF_BITS'($signed(xreq.pb[j]))
						- DIFF_BITS'($signed(xreq.pa[j]));
				end
			end
			C_PREP: begin
				den_q <= {1'b0, ma_q} + {1'b0, mb_q};
				rem_q <= REM_BITS'(ma_q);
				quo_q <= '0;
				for (int j = 0; j < 3; j++) begin
					neg_q[j] <= delta_q[j][DIFF_BITS-1];
					mag_q[j] <= delta_q[j][DIFF_BITS-1] ? COORD_BITS'(-delta_q[j])
						: COORD_BITS'(delta_q[j]);
				end
			end
			C_DIV: begin
				rem_q <= ge ? rem_sh - REM_BITS'(den_q) : rem_sh;
				quo_q <= {quo_q[T_BITS-2:0], ge};
			end
			C_MUL: begin
				for (int j = 0; j < 3; j++) begin
					ph_q[j] <= PART_BITS'(mag_q[j]) * PART_BITS'(quo_q[T_BITS-1:T_LO_BITS]);
					pl_q[j] <= PART_BITS'(mag_q[j]) * PART_BITS'(quo_q[T_LO_BITS-1:0]);
				end
			end
			C_SUM: begin
				for (int j = 0; j < 3; j++) begin
					step_q[j] <= acc[j][T_BITS +: COORD_BITS];
				end
			end
			C_ADD: begin
				for (int j = 0; j < 3; j++) begin
					if (sum_v[j][STEP_BITS-1:COORD_BITS-1] == '0
						|| sum_v[j][STEP_BITS-1:COORD_BITS-1] == '1) begin
						res_q[j] <= sum_v[j][COORD_BITS-1:0];
					end else if (sum_v[j][STEP_BITS-1]) begin
						res_q[j] <= {1'b1, {(COORD_BITS-1){1'b0}}};
					end else begin
						res_q[j] <= {1'b0, {(COORD_BITS-1){1'b1}}};
					end
				end
			end
			default: ;
		endcase
	end

	assign xrsp.done = done_q;
	assign xrsp.res  = res_q;
endmodule

/* src/pps_back.sv */
// ----------------------------------------------------------------------------
// pps_back: split planning, crossing sequencing and piece emission
// Takes one classified primitive at a time and drives the output register.
// ----------------------------------------------------------------------------
module pps_back import pps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  q_entry_t  q_head,
	output logic      pop,
	output xreq_t     xreq,
	input  xrsp_t     xrsp,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	typedef enum logic [2:0] {
		ST_LOAD, ST_X1_GO, ST_X1_WAIT, ST_X2_GO, ST_X2_WAIT, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       last;
		logic [1:0]       n_cross;
		logic [1:0]       x1_a;
		logic [1:0]       x1_b;
		logic [1:0]       x2_a;
		logic [1:0]       x2_b;
		side_t [2:0]      side;
		vsel_t [2:0][2:0] sel;
	} plan_t;

	state_t     state_q;
	logic [1:0] piece_q;
	logic       out_valid_q;
	out_item_t  out_item_q;
	plan_t      plan_q;
	q_entry_t   ent_q;
	vec3_t      x1_q, x2_q;

	plan_t      plan;
	logic [1:0] ia, ib;
	vtx3_t      pv;
	out_item_t  out_next;
	logic       out_free, emit_fire;

	function automatic side_t side_of(input int v);
		return (v > 0) ? SIDE_FRONT : ((v < 0) ? SIDE_BACK : SIDE_ON);
	endfunction

	function automatic logic [1:0] nxt(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	always_comb begin
		int sg [3];
		int sum;
		int nz;
		logic [1:0] z, a, b, k;
		plan = '0;
		z = '0;
		a = '0;
		b = '0;
		k = '0;
		for (int i = 0; i < 3; i++) begin
			sg[i] = (q_head.side[i] == SIDE_FRONT) ? 1 : ((q_head.side[i] == SIDE_BACK) ? -1 : 0);
		end
		sum = 0;
		nz  = 0;
		unique case (q_head.kind)
			KIND_POINT: begin
				plan.side[0]   = side_of(sg[0]);
				plan.sel[0][1] = SEL_ZERO;
				plan.sel[0][2] = SEL_ZERO;
			end
			KIND_LINE: begin
				plan.sel[0][2] = SEL_ZERO;
				plan.sel[1][2] = SEL_ZERO;
				sum = sg[0] + sg[1];
				if (sg[0] == 0 && sg[1] == 0) begin
					plan.side[0] = SIDE_ON;
				end else if (sum != 0) begin
					plan.side[0] = side_of(sum);
				end else begin
					plan.last    = 2'd1;
					plan.n_cross = 2'd1;
					plan.x1_a    = 2'd0;
					plan.x1_b    = 2'd1;
					plan.side[0] = SIDE_FRONT;
					plan.side[1] = SIDE_BACK;
					if (sg[0] < 0) begin
						plan.sel[0][0] = SEL_X1;
						plan.sel[1][1] = SEL_X1;
					end else begin
						plan.sel[0][1] = SEL_X1;
						plan.sel[1][0] = SEL_X1;
					end
				end
			end
			default: begin
				sum = sg[0] + sg[1] + sg[2];
				nz  = int'(sg[0] == 0) + int'(sg[1] == 0) + int'(sg[2] == 0);
				if (nz == 3) begin
					plan.side[0] = SIDE_ON;
				end else if (sum + nz == 3) begin
					plan.side[0] = SIDE_FRONT;
				end else if (sum - nz == -3) begin
					plan.side[0] = SIDE_BACK;
				end else if (nz == 1) begin
					z = (sg[0] == 0) ? 2'd0 : ((sg[1] == 0) ? 2'd1 : 2'd2);
					a = nxt(z);
					b = nxt(a);
					plan.last      = 2'd1;
					plan.n_cross   = 2'd1;
					plan.x1_a      = a;
					plan.x1_b      = b;
					plan.sel[0][b] = SEL_X1;
					plan.side[0]   = side_of(sg[a]);
					plan.sel[1][a] = SEL_X1;
					plan.side[1]   = side_of(sg[b]);
				end else begin
					k = (sg[1] == sg[2]) ? 2'd0 : ((sg[0] == sg[2]) ? 2'd1 : 2'd2);
					a = nxt(k);
					b = nxt(a);
					plan.last      = 2'd2;
					plan.n_cross   = 2'd2;
					plan.x1_a      = k;
					plan.x1_b      = a;
					plan.x2_a      = k;
					plan.x2_b      = b;
					plan.sel[0][a] = SEL_X1;
					plan.sel[0][b] = SEL_X2;
					plan.side[0]   = side_of(sg[k]);
					plan.sel[1][k] = SEL_X1;
					plan.sel[1][b] = SEL_X2;
					plan.side[1]   = side_of(-sg[k]);
					plan.sel[2][k] = SEL_X2;
					plan.side[2]   = side_of(-sg[k]);
				end
			end
		endcase
	end

	assign ia = (state_q == ST_X2_GO) ? plan_q.x2_a : plan_q.x1_a;
	assign ib = (state_q == ST_X2_GO) ? plan_q.x2_b : plan_q.x1_b;

	always_comb begin
		xreq.start = (state_q == ST_X1_GO) || (state_q == ST_X2_GO);
		xreq.pa    = ent_q.vtx[ia];
		xreq.pb    = ent_q.vtx[ib];
		xreq.da    = ent_q.vdist[ia];
		xreq.db    = ent_q.vdist[ib];
	end

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			case (plan_q.sel[piece_q][m])
				SEL_ORIG: pv[m] = ent_q.vtx[m];
				SEL_X1:   pv[m] = x1_q;
				SEL_X2:   pv[m] = x2_q;
				SEL_ZERO: pv[m] = '0;
			endcase
		end
		out_next.side       = plan_q.side[piece_q];
		out_next.src_tag    = ent_q.tag;
		out_next.p0_x       = pv[0][0];
		out_next.p0_y       = pv[0][1];
		out_next.p0_z       = pv[0][2];
		out_next.p1_x       = pv[1][0];
		out_next.p1_y       = pv[1][1];
		out_next.p1_z       = pv[1][2];
		out_next.p2_x       = pv[2][0];
		out_next.p2_y       = pv[2][1];
		out_next.p2_z       = pv[2][2];
		out_next.last_piece = (piece_q == plan_q.last);
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign pop       = (state_q == ST_LOAD) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			piece_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						piece_q <= '0;
						state_q <= (plan.n_cross != 2'd0) ? ST_X1_GO : ST_EMIT;
					end
				end
				ST_X1_GO: state_q <= ST_X1_WAIT;
				ST_X1_WAIT: begin
					if (xrsp.done) begin
						state_q <= (plan_q.n_cross == 2'd2) ? ST_X2_GO : ST_EMIT;
					end
				end
				ST_X2_GO: state_q <= ST_X2_WAIT;
				ST_X2_WAIT: if (xrsp.done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						if (piece_q == plan_q.last) begin
							state_q <= ST_LOAD;
						end else begin
							piece_q <= piece_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= q_head;
			plan_q <= plan;
		end
		if (state_q == ST_X1_WAIT && xrsp.done) begin
			x1_q <= xrsp.res;
		end
		if (state_q == ST_X2_WAIT && xrsp.done) begin
			x2_q <= xrsp.res;
		end
		if (emit_fire) begin
			out_item_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
endmodule

/* src/primitive_plane_split.sv */
// ----------------------------------------------------------------------------
// primitive_plane_split: split points, segments and triangles by a plane
// Classifies each primitive against the configured plane and emits pieces.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_item carries one primitive per transfer;
// output channel out_valid/out_stall/out_item carries one piece per transfer,
// last_piece marks the final piece of a primitive. Empty primitives give none.
// Plane registers are written over cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// The front end is a four-stage pipeline taking one primitive per cycle while
// in_stall is low; a queue of QUEUE_DEPTH entries feeds the back end.
// Each crossing point is found in the shared crossing unit by its 30-step
// restoring division of t: one crossing for a split segment or a split
// triangle with a vertex on the plane, two for other split triangles.
// Reset clears the queue and the pipeline and loads the register defaults.
// When out_stall is high the piece is held on out_item; the front end keeps
// accepting until the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module primitive_plane_split import pps_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_item,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_item
);
	logic     push, q_full, pop, q_valid;
	q_entry_t push_entry, q_head;
	xreq_t    xreq;
	xrsp_t    xrsp;

	pps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	pps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	pps_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.xreq   (xreq),
		.xrsp   (xrsp)
	);

	pps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.xreq      (xreq),
		.xrsp      (xrsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule

/* src/pps_checker.sv */
// ----------------------------------------------------------------------------
// pps_checker: port-level checks of the primitive plane splitter
// Bound to the top level; watches the output channel over time.
// ----------------------------------------------------------------------------
module pps_checker import pps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled piece changed");

	a_split_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_piece
		|-> out_item.side == SIDE_FRONT || out_item.side == SIDE_BACK)
		else $error("split piece on plane");

	a_split_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_piece
		|=> out_valid && out_item.src_tag == $past(out_item.src_tag))
		else $error("pieces of one primitive not back to back");
endmodule

bind primitive_plane_split pps_checker u_pps_checker (.*);

/* tb/primitive_plane_split_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_plane_split_tb: self-checking bench of the primitive plane splitter
// Drives points, segments and triangles under several plane settings and
// compares every piece against a bit-exact split predictor.
// ----------------------------------------------------------------------------
module primitive_plane_split_tb;
	import pps_pkg::*;

	class split_board;
		longint nrm[3];
		longint anc[3];
		longint band;
		out_item_t pieces_due[$];
		int errors;

		function new();
			nrm = '{0, 0, 65536};
			anc = '{0, 0, 0};
			band = 1;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_BITS-1:0] d);
			case (r)
				REG_NORMAL_X: nrm[0] = longint'($signed(d[NORM_BITS-1:0]));
				REG_NORMAL_Y: nrm[1] = longint'($signed(d[NORM_BITS-1:0]));
				REG_NORMAL_Z: nrm[2] = longint'($signed(d[NORM_BITS-1:0]));
				REG_ANCHOR_X: anc[0] = longint'($signed(d));
				REG_ANCHOR_Y: anc[1] = longint'($signed(d));
				REG_ANCHOR_Z: anc[2] = longint'($signed(d));
				REG_DEAD_BAND: band = longint'(d[BAND_BITS-1:0]);
				default: ;
			endcase
		endfunction

		function longint plane_dist(longint p[3]);
			longint d;
			d = 0;
			for (int i = 0; i < 3; i++) d += nrm[i] * (p[i] - anc[i]);
			return d;
		endfunction

		function int classify(longint d);
			longint thr;
			thr = band << FRAC_BITS;
			return d > thr ? 1 : (d < -thr ? -1 : 0);
		endfunction

		function side_t side_of(int s);
			return s > 0 ? SIDE_FRONT : (s < 0 ? SIDE_BACK : SIDE_ON);
		endfunction

		function longint unsigned ratio(longint unsigned num, longint unsigned den);
			longint unsigned r, q;
			r = num;
			q = 0;
			if (den == 0 || num >= den) return 0;
			for (int i = 0; i < T_BITS; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r -= den;
					q |= 1;
				end
			end
			return q;
		endfunction

		function void crossing(longint pa[3], longint pb[3], longint da, longint db,
				output longint res[3]);
			longint unsigned ma, mb, t, mag, stp;
			longint delta, v;
			ma = da < 0 ? longint'(-da) : longint'(da);
			mb = db < 0 ? longint'(-db) : longint'(db);
			t = ratio(ma, ma + mb);
			for (int i = 0; i < 3; i++) begin
				delta = pb[i] - pa[i];
				mag = delta < 0 ? longint'(-delta) : longint'(delta);
				stp = (mag * t + (64'd1 << (T_BITS - 1))) >> T_BITS;
				v = delta < 0 ? pa[i] - longint'(stp) : pa[i] + longint'(stp);
				if (v > 64'sd2147483647) v = 64'sd2147483647;
				if (v < -64'sd2147483648) v = -64'sd2147483648;
				res[i] = v;
			end
		endfunction

		function void add_piece(int s, logic [TAG_BITS-1:0] tag, longint pts[3][3], int nv);
			out_item_t o;
			coord_t c[9];
			for (int i = 0; i < 9; i++) c[i] = (i / 3 < nv) ? coord_t'(pts[i / 3][i % 3]) : '0;
			o.side = side_of(s);
			o.src_tag = tag;
			o.p0_x = c[0]; o.p0_y = c[1]; o.p0_z = c[2];
			o.p1_x = c[3]; o.p1_y = c[4]; o.p1_z = c[5];
			o.p2_x = c[6]; o.p2_y = c[7]; o.p2_z = c[8];
			o.last_piece = 1'b0;
			pieces_due.insert(pieces_due.size(), o);
		endfunction

		function void note_primitive(in_item_t it);
			longint v[3][3], pc[3][3], d[3], np[3], q1[3], q2[3];
			int s[3], nv, sum, nz, z, a, b, k, first;
			if (it.kind == KIND_EMPTY) return;
			first = pieces_due.size();
			v[0] = '{it.v0_x, it.v0_y, it.v0_z};
			v[1] = '{it.v1_x, it.v1_y, it.v1_z};
			v[2] = '{it.v2_x, it.v2_y, it.v2_z};
			nv = it.kind == KIND_TRI ? 3 : (it.kind == KIND_LINE ? 2 : 1);
			s = '{0, 0, 0};
			d = '{0, 0, 0};
			for (int i = 0; i < nv; i++) begin
				d[i] = plane_dist(v[i]);
				s[i] = classify(d[i]);
			end
			pc = v;
			if (it.kind == KIND_POINT) begin
				add_piece(s[0], it.tag, pc, 1);
			end else if (it.kind == KIND_LINE) begin
				sum = s[0] + s[1];
				if (s[0] == 0 && s[1] == 0) add_piece(0, it.tag, pc, 2);
				else if (sum != 0) add_piece(sum, it.tag, pc, 2);
				else begin
					crossing(v[0], v[1], d[0], d[1], np);
					pc[s[0] < 0 ? 0 : 1] = np;
					add_piece(1, it.tag, pc, 2);
					pc = v;
					pc[s[0] < 0 ? 1 : 0] = np;
					add_piece(-1, it.tag, pc, 2);
				end
			end else begin
				sum = s[0] + s[1] + s[2];
				nz = (s[0] == 0) + (s[1] == 0) + (s[2] == 0);
				if (nz == 3) add_piece(0, it.tag, pc, 3);
				else if (sum + nz == 3) add_piece(1, it.tag, pc, 3);
				else if (sum - nz == -3) add_piece(-1, it.tag, pc, 3);
				else if (nz == 1) begin
					z = s[0] == 0 ? 0 : (s[1] == 0 ? 1 : 2);
					a = (z + 1) % 3;
					b = (z + 2) % 3;
					crossing(v[a], v[b], d[a], d[b], np);
					pc[b] = np;
					add_piece(s[a], it.tag, pc, 3);
					pc = v;
					pc[a] = np;
					add_piece(s[b], it.tag, pc, 3);
				end else begin
					k = s[1] == s[2] ? 0 : (s[0] == s[2] ? 1 : 2);
					a = (k + 1) % 3;
					b = (k + 2) % 3;
					crossing(v[k], v[a], d[k], d[a], q1);
					crossing(v[k], v[b], d[k], d[b], q2);
					pc[a] = q1;
					pc[b] = q2;
					add_piece(s[k], it.tag, pc, 3);
					pc = v;
					pc[k] = q1;
					pc[b] = q2;
					add_piece(-s[k], it.tag, pc, 3);
					pc = v;
					pc[k] = q2;
					add_piece(-s[k], it.tag, pc, 3);
				end
			end
			if (pieces_due.size() > first) pieces_due[pieces_due.size() - 1].last_piece = 1'b1;
		endfunction

		task report(string what, longint e, longint g);
			$display("mismatch %s: expected %0h got %0h", what, e, g);
			errors++;
		endtask

		task check_piece(out_item_t g);
			out_item_t e;
			if (pieces_due.size() == 0) begin
				report("unexpected piece tag", 0, g.src_tag);
				return;
			end
			e = pieces_due.pop_front();
			if (e.side !== g.side) report("side", e.side, g.side);
			if (e.src_tag !== g.src_tag) report("src_tag", e.src_tag, g.src_tag);
			if (e.p0_x !== g.p0_x) report("p0_x", e.p0_x, g.p0_x);
			if (e.p0_y !== g.p0_y) report("p0_y", e.p0_y, g.p0_y);
			if (e.p0_z !== g.p0_z) report("p0_z", e.p0_z, g.p0_z);
			if (e.p1_x !== g.p1_x) report("p1_x", e.p1_x, g.p1_x);
			if (e.p1_y !== g.p1_y) report("p1_y", e.p1_y, g.p1_y);
			if (e.p1_z !== g.p1_z) report("p1_z", e.p1_z, g.p1_z);
			if (e.p2_x !== g.p2_x) report("p2_x", e.p2_x, g.p2_x);
			if (e.p2_y !== g.p2_y) report("p2_y", e.p2_y, g.p2_y);
			if (e.p2_z !== g.p2_z) report("p2_z", e.p2_z, g.p2_z);
			if (e.last_piece !== g.last_piece) report("last_piece", e.last_piece, g.last_piece);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	split_board board;
	bit quiet;
	bit send_gaps;
	bit hold_req;
	int idle_cycles;
	logic [15:0] next_tag;

	primitive_plane_split uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always #5 clk = ~clk;

	task send_primitive(in_item_t it);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_primitive(it);
		if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task set_plane(logic [CFG_BITS-1:0] vals[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data <= vals[i];
			board.set_reg(cfg_reg_t'(i), vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (board.pieces_due.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function coord_t pick_coord(int axis);
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			2: return coord_t'(board.anc[axis] + int'($urandom_range(0, 1 << 19)) - (1 << 18));
			3: return coord_t'(board.anc[axis] + int'($urandom_range(0, 2)) - 1);
			4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return coord_t'(board.anc[axis] + int'($urandom_range(0, 1 << 24))
				- (1 << 23));
		endcase
	endfunction

	function in_item_t random_primitive();
		in_item_t it;
		int r;
		r = $urandom_range(0, 15);
		it.kind = r < 7 ? KIND_TRI : (r < 12 ? KIND_LINE : (r < 15 ? KIND_POINT : KIND_EMPTY));
		it.tag = 16'($urandom);
		it.v0_x = pick_coord(0); it.v0_y = pick_coord(1); it.v0_z = pick_coord(2);
		it.v1_x = pick_coord(0); it.v1_y = pick_coord(1); it.v1_z = pick_coord(2);
		it.v2_x = pick_coord(0); it.v2_y = pick_coord(1); it.v2_z = pick_coord(2);
		return it;
	endfunction

	function in_item_t z_primitive(kind_t k, int z0, int z1, int z2);
		in_item_t it;
		it = random_primitive();
		it.kind = k;
		it.tag = next_tag;
		next_tag++;
		it.v0_z = coord_t'(z0 * 65536);
		it.v1_z = coord_t'(z1 * 65536);
		it.v2_z = coord_t'(z2 * 65536);
		return it;
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) board.check_piece(out_item);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [CFG_BITS-1:0] plane[7];
		in_item_t it;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		quiet = 1'b0;
		send_gaps = 1'b1;
		hold_req = 1'b0;
		next_tag = 16'h0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset plane: z = 0, normal +z, unit dead band
		send_primitive(z_primitive(KIND_EMPTY, 1, 1, 1));
		send_primitive(z_primitive(KIND_POINT, 1, 0, 0));
		send_primitive(z_primitive(KIND_POINT, -1, 0, 0));
		send_primitive(z_primitive(KIND_POINT, 0, 0, 0));
		send_primitive(z_primitive(KIND_LINE, 2, -3, 0));
		send_primitive(z_primitive(KIND_LINE, -5, 1, 0));
		send_primitive(z_primitive(KIND_LINE, 0, 4, 0));
		send_primitive(z_primitive(KIND_LINE, 0, 0, 0));
		send_primitive(z_primitive(KIND_TRI, 0, 0, 0));
		send_primitive(z_primitive(KIND_TRI, 1, 0, 2));
		send_primitive(z_primitive(KIND_TRI, -1, -2, 0));
		send_primitive(z_primitive(KIND_TRI, 0, 3, -1));
		send_primitive(z_primitive(KIND_TRI, -2, 0, 5));
		send_primitive(z_primitive(KIND_TRI, 3, -1, -2));
		send_primitive(z_primitive(KIND_TRI, -4, 1, -1));
		send_primitive(z_primitive(KIND_TRI, -1, -3, 2));
		it = z_primitive(KIND_LINE, 0, 0, 0);
		it.v0_x = 32'sh80000000; it.v0_y = 32'sh7fffffff; it.v0_z = 32'sh7fffffff;
		it.v1_x = 32'sh7fffffff; it.v1_y = 32'sh80000000; it.v1_z = 32'sh80000000;
		it.tag = 16'hffff;
		send_primitive(it);
		it.kind = KIND_TRI;
		it.tag = 16'h0000;
		it.v2_x = 32'sh0; it.v2_y = 32'sh7fffffff; it.v2_z = 32'sh80000000;
		send_primitive(it);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: plane = '{32'h1ffff, 32'h20000, 32'h0, 32'h7fffffff, 32'h80000000,
					32'h0, 32'h0};
				1: plane = '{32'h0, 32'h10000, 32'h30000, 32'h0, 32'h12345678,
					32'hfff00000, 32'hffff};
				2: plane = '{32'h3ffff & (-32'sd65536), 32'h0, 32'h0, 32'h80000000, 32'h0,
					32'h7fffffff, 32'h1};
				default: begin
					for (int i = 0; i < 3; i++)
						plane[i] = 32'(int'($urandom_range(0, 131072)) - 65536);
					for (int i = 3; i < 6; i++)
						plane[i] = $urandom_range(0, 1) ? $urandom :
							32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
					plane[6] = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
				end
			endcase
			set_plane(plane);
			quiet = (ph == 6);
			if (ph == 3) begin
				send_gaps = 1'b0;
				hold_req = 1'b1;
			end
			for (int n = 0; n < 52; n++) begin
				send_primitive(random_primitive());
				if (ph == 3 && n == 30) send_gaps = 1'b1;
			end
			drain();
		end

		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
